// File: hdl/imf_pkg.sv
// ----------------------------------------------------------------------------
// imf_pkg
// shared types, register indexes and defaults of the 3x3 image filter
// ----------------------------------------------------------------------------
`default_nettype none

package imf_pkg;

  localparam int MAX_WIDTH_DEF    = 1024;
  localparam int CHANNEL_BITS_DEF = 8;
  localparam int ROW_BITS         = 12;
  localparam int GEO_BITS         = 15;
  localparam int QUEUE_DEPTH      = 4;
  localparam int OUT_DEPTH        = 8;
  localparam int CFG_INDEX_BITS   = 4;
  localparam int CFG_DATA_BITS    = 11;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_IMAGE_WIDTH   = 4'd0,
    CFG_IMAGE_HEIGHT  = 4'd1,
    CFG_SEL_ROW_FIRST = 4'd2,
    CFG_SEL_ROW_END   = 4'd3,
    CFG_SEL_COL_FIRST = 4'd4,
    CFG_SEL_COL_END   = 4'd5,
    CFG_FILTER_KIND   = 4'd6,
    CFG_MAX_VALUE     = 4'd7
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_EDGE    = 2'd0,
    KIND_SHARPEN = 2'd1,
    KIND_BOX     = 2'd2,
    KIND_GAUSS   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [10:0] image_width;
    logic [10:0] image_height;
    logic [9:0]  sel_row_first;
    logic [10:0] sel_row_end;
    logic [9:0]  sel_col_first;
    logic [10:0] sel_col_end;
    kind_t       filter_kind;
    logic [7:0]  max_value;
  } cfg_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_last;
  } out_item_t;

  typedef struct packed {
    logic has_result;
    logic in_sel;
    logic last;
  } ctrl_t;

endpackage

`default_nettype wire

// File: hdl/imf_ram.sv
// ----------------------------------------------------------------------------
// imf_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module imf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/imf_fifo.sv
// ----------------------------------------------------------------------------
// imf_fifo
// small register queue with occupancy count
// ----------------------------------------------------------------------------
`default_nettype none

module imf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       pop,
  output logic      [WIDTH-1:0]           rdata,
  output logic                            full,
  output logic                            empty,
  output logic      [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == ($clog2(DEPTH+1))'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/imf_front.sv
// ----------------------------------------------------------------------------
// imf_front
// configuration registers, raster counters and classification of items
// ----------------------------------------------------------------------------
`default_nettype none

module imf_front import imf_pkg::*; #(
  parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  wire logic                          push,
  input  wire in_item_t                      item,
  output logic                               full,
  input  wire logic                          q_full,
  output logic                               q_push,
  output logic      [3*CHANNEL_BITS-1:0]     q_px,
  output logic      [$clog2(MAX_WIDTH)-1:0]  q_col,
  output ctrl_t                              q_ctrl,
  output cfg_t                               cfg
);

  localparam int CLW = $clog2(MAX_WIDTH + 1);
  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int SW  = CLW + ROW_BITS;
  localparam int GW  = GEO_BITS;
  localparam int CB  = CHANNEL_BITS;

  logic [CLW-1:0]      in_col;
  logic [ROW_BITS-1:0] in_row;
  logic [CLW-1:0]      out_col;
  logic [ROW_BITS-1:0] out_row;
  logic [SW-1:0]       slot;
  logic [SW-1:0]       total;

  logic [GW-1:0] w_eff;
  logic [GW-1:0] h_eff;
  logic [GW-1:0] wx;
  logic [GW-1:0] inc;
  logic [GW-1:0] colm;
  logic [GW-1:0] r;
  logic [GW-1:0] c;
  logic          in_frame;
  logic          ignore;
  logic          take;
  logic          has_result;
  logic          in_sel;
  logic          last;

  always_comb begin
    wx = GW'(cfg.image_width);
    if (wx == '0) begin
      w_eff = GW'(1);
    end else if (wx > GW'(MAX_WIDTH)) begin
      w_eff = GW'(MAX_WIDTH);
    end else begin
      w_eff = wx;
    end
    h_eff = (cfg.image_height == '0) ? GW'(1) : GW'(cfg.image_height);
  end

  // slot follows the current geometry
  assign slot  = SW'(in_row) * SW'(w_eff) + SW'(in_col);
  assign total = SW'(w_eff) * SW'(h_eff);

  assign in_frame   = (slot < total);
  assign ignore     = item.mode && in_frame;
  assign full       = q_full;
  assign take       = push && !q_full && !ignore;
  assign has_result = (slot > SW'(w_eff));

  assign inc  = GW'(in_col);
  assign colm = (inc >= GW'(MAX_WIDTH)) ? inc - GW'(MAX_WIDTH) : inc;
  assign r    = GW'(out_row);
  assign c    = GW'(out_col);

  assign in_sel = (r >= GW'(1)) && (r + 1'b1 < h_eff) && (c >= GW'(1)) && (c + 1'b1 < w_eff) &&
                  (r >= GW'(cfg.sel_row_first)) && (r < GW'(cfg.sel_row_end)) &&
                  (c >= GW'(cfg.sel_col_first)) && (c < GW'(cfg.sel_col_end));
  assign last   = (r >= h_eff) || ((r + 1'b1 == h_eff) && (c + 1'b1 >= w_eff));

  assign q_push            = take;
  assign q_col             = AW'(colm);
  assign q_ctrl.has_result = has_result;
  assign q_ctrl.in_sel     = in_sel;
  assign q_ctrl.last       = last;

  always_comb begin
    if (in_frame && !item.mode) begin
      q_px = {CB'(item.in_blue), CB'(item.in_green), CB'(item.in_red)};
    end else begin
      q_px = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width   <= 11'd1024;
      cfg.image_height  <= 11'd1024;
      cfg.sel_row_first <= '0;
      cfg.sel_row_end   <= 11'd1024;
      cfg.sel_col_first <= '0;
      cfg.sel_col_end   <= 11'd1024;
      cfg.filter_kind   <= KIND_EDGE;
      cfg.max_value     <= 8'd255;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:   cfg.image_width   <= cfg_data;
        CFG_IMAGE_HEIGHT:  cfg.image_height  <= cfg_data;
        CFG_SEL_ROW_FIRST: cfg.sel_row_first <= cfg_data[9:0];
        CFG_SEL_ROW_END:   cfg.sel_row_end   <= cfg_data;
        CFG_SEL_COL_FIRST: cfg.sel_col_first <= cfg_data[9:0];
        CFG_SEL_COL_END:   cfg.sel_col_end   <= cfg_data;
        CFG_FILTER_KIND:   cfg.filter_kind   <= kind_t'(cfg_data[1:0]);
        CFG_MAX_VALUE:     cfg.max_value     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (take) begin
      if (has_result && last) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        if (inc + 1'b1 >= w_eff) begin
          in_col <= '0;
          in_row <= in_row + 1'b1;
        end else begin
          in_col <= in_col + 1'b1;
        end
        if (has_result) begin
          if (c + 1'b1 >= w_eff) begin
            out_col <= '0;
            out_row <= out_row + 1'b1;
          end else begin
            out_col <= out_col + 1'b1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/imf_back.sv
// ----------------------------------------------------------------------------
// imf_back
// line buffers, 3x3 window, kernel sums, rounding divide and clamp
// ----------------------------------------------------------------------------
`default_nettype none

module imf_back import imf_pkg::*; #(
  parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire cfg_t                             cfg,
  input  wire logic                             q_empty,
  input  wire logic [3*CHANNEL_BITS-1:0]        q_px,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]     q_col,
  input  wire ctrl_t                            q_ctrl,
  output logic                                  q_pop,
  input  wire logic [$clog2(OUT_DEPTH+1)-1:0]   o_count,
  output logic                                  o_push,
  output out_item_t                             o_data
);

  localparam int CB    = CHANNEL_BITS;
  localparam int PW    = 3 * CB;
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int SW    = CB + 6;
  localparam int UW    = CB + 5;
  localparam int XW    = CB + 7;
  localparam int K     = CB + 9;
  localparam int RECIP = (2 ** K + 17) / 18;
  localparam int OCW   = $clog2(OUT_DEPTH + 1);

  logic          s1_v;
  logic [PW-1:0] s1_px;
  logic [AW-1:0] s1_col;
  ctrl_t         s1_ctrl;
  logic [PW-1:0] l0_q;
  logic [PW-1:0] l1_q;
  logic [PW-1:0] l0_eff;
  logic [PW-1:0] l1_eff;
  logic          fwd;
  logic [PW-1:0] fwd_l0;
  logic [PW-1:0] fwd_l1;

  logic [PW-1:0] win [3][3];
  logic          s2_v;
  ctrl_t         s2_ctrl;

  logic                 s3_v;
  ctrl_t                s3_ctrl;
  logic signed [SW-1:0] s3_sum [3];
  logic [PW-1:0]        s3_center;
  logic signed [SW-1:0] sum_c [3];

  logic      s4_v;
  ctrl_t     s4_ctrl;
  logic [7:0] s4_ch [3];
  logic [7:0] val_c [3];

  logic [OCW+2:0] busy;

  assign busy  = (OCW+3)'(o_count) + (OCW+3)'(s1_v) + (OCW+3)'(s2_v) + (OCW+3)'(s3_v) +
                 (OCW+3)'(s4_v);
  assign q_pop = !q_empty && (busy < (OCW+3)'(OUT_DEPTH));

  imf_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_row0 (
    .clk   (clk),
    .we    (s1_v),
    .waddr (s1_col),
    .wdata (s1_px),
    .raddr (q_col),
    .rdata (l0_q)
  );

  imf_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_row1 (
    .clk   (clk),
    .we    (s1_v),
    .waddr (s1_col),
    .wdata (l0_eff),
    .raddr (q_col),
    .rdata (l1_q)
  );

  assign l0_eff = fwd ? fwd_l0 : l0_q;
  assign l1_eff = fwd ? fwd_l1 : l1_q;

  always_ff @(posedge clk) begin
    s1_px   <= q_px;
    s1_col  <= q_col;
    s1_ctrl <= q_ctrl;
    fwd_l0  <= s1_px;
    fwd_l1  <= l0_eff;
    s2_ctrl <= s1_ctrl;
    s3_ctrl <= s2_ctrl;
    s4_ctrl <= s3_ctrl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      fwd  <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else begin
      s1_v <= q_pop;
      fwd  <= q_pop && s1_v && (q_col == s1_col);
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
  end

  // window shifts left, new column enters on the right
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (s1_v) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= l1_eff;
      win[1][2] <= l0_eff;
      win[2][2] <= s1_px;
    end
  end

  always_comb begin
    logic signed [SW-1:0] p [3][3];
    logic signed [SW-1:0] corners;
    logic signed [SW-1:0] edges;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p[i][j] = $signed(SW'(win[i][j][k*CB +: CB]));
        end
      end
      corners = p[0][0] + p[0][2] + p[2][0] + p[2][2];
      edges   = p[0][1] + p[1][0] + p[1][2] + p[2][1];
      case (cfg.filter_kind)
        KIND_EDGE:    sum_c[k] = (p[1][1] <<< 3) - corners - edges;
        KIND_SHARPEN: sum_c[k] = (p[1][1] <<< 2) + p[1][1] - edges;
        KIND_BOX:     sum_c[k] = corners + edges + p[1][1];
        KIND_GAUSS:   sum_c[k] = corners + (edges <<< 1) + (p[1][1] <<< 2);
        default:      sum_c[k] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      s3_sum[k] <= sum_c[k];
    end
    s3_center <= win[1][1];
  end

  always_comb begin
    logic [UW-1:0]   u;
    logic [XW-1:0]   x;
    logic [XW+K-1:0] prod;
    logic [UW-1:0]   q;
    for (int k = 0; k < 3; k++) begin
      u    = UW'(s3_sum[k]);
      x    = (XW'(u) << 1) + XW'(9);
      prod = (XW+K)'(x) * (XW+K)'(RECIP);
      case (cfg.filter_kind)
        KIND_EDGE:    q = u;
        KIND_SHARPEN: q = u;
        KIND_BOX:     q = UW'(prod >> K);
        KIND_GAUSS:   q = UW'((u + UW'(8)) >> 4);
        default:      q = u;
      endcase
      if (s3_sum[k] <= 0) begin
        q = '0;
      end
      if (q > UW'(cfg.max_value)) begin
        q = UW'(cfg.max_value);
      end
      val_c[k] = s3_ctrl.in_sel ? 8'(q) : 8'(s3_center[k*CB +: CB]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      s4_ch[k] <= val_c[k];
    end
  end

  assign o_push            = s4_v && s4_ctrl.has_result;
  assign o_data.out_red    = s4_ch[0];
  assign o_data.out_green  = s4_ch[1];
  assign o_data.out_blue   = s4_ch[2];
  assign o_data.frame_last = s4_ctrl.last;

endmodule

`default_nettype wire

// File: hdl/image_filter_3x3.sv
// ----------------------------------------------------------------------------
// image_filter_3x3
// streaming 3x3 rgb convolution with selection rectangle
//
// input channel: push/full, one pixel or drain tick per transfer, raster order.
// result channel: empty/pop, oldest result on result while empty is low.
// config: cfg_we/cfg_index/cfg_data, written while the block is idle.
// a pixel comes out once the image width plus two further items have entered;
// drain ticks flush the last pixels of the frame, frame_last marks the end.
// throughput is one item per cycle; the front classifies an item in the
// cycle it is taken, the back passes it through line buffer read, window,
// kernel sums, and divide and clamp stages before the result enters an
// eight-entry output queue. when pop stays low the output queue fills, the
// back stops taking items from its four-entry queue, and full rises once
// that fills. reset restores the default geometry and filter, clears
// counters, window and queues; line buffer contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module image_filter_3x3 import imf_pkg::*; #(
  parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                      push,
  input  wire in_item_t                  item,
  output logic                           full,
  output logic                           empty,
  input  wire logic                      pop,
  output out_item_t                      result
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int PW = 3 * CHANNEL_BITS;
  localparam int QW = $bits(ctrl_t) + AW + PW;

  cfg_t          cfg;
  logic          q_push;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  logic [PW-1:0] f_px;
  logic [AW-1:0] f_col;
  ctrl_t         f_ctrl;
  logic [QW-1:0] q_rdata;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
  logic [PW-1:0] b_px;
  logic [AW-1:0] b_col;
  ctrl_t         b_ctrl;

  logic      o_push;
  logic      o_full;
  out_item_t o_data;
  logic [$clog2(OUT_DEPTH+1)-1:0] o_count;

  imf_front #(.MAX_WIDTH(MAX_WIDTH), .CHANNEL_BITS(CHANNEL_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .item      (item),
    .full      (full),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_px      (f_px),
    .q_col     (f_col),
    .q_ctrl    (f_ctrl),
    .cfg       (cfg)
  );

  imf_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata ({f_ctrl, f_col, f_px}),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty),
    .count (q_count)
  );

  assign {b_ctrl, b_col, b_px} = q_rdata;

  imf_back #(.MAX_WIDTH(MAX_WIDTH), .CHANNEL_BITS(CHANNEL_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_px    (b_px),
    .q_col   (b_col),
    .q_ctrl  (b_ctrl),
    .q_pop   (q_pop),
    .o_count (o_count),
    .o_push  (o_push),
    .o_data  (o_data)
  );

  imf_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(OUT_DEPTH)) u_out (
    .clk   (clk),
    .rst   (rst),
    .push  (o_push),
    .wdata (o_data),
    .pop   (pop),
    .rdata (result),
    .full  (o_full),
    .empty (empty),
    .count (o_count)
  );

  a_out_room: assert property (@(posedge clk) disable iff (rst) o_push |-> !o_full)
    else $error("result lost on full output queue");

  a_queue_room: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("item lost on full queue");

  a_reset_empty: assert property (@(posedge clk) rst |=> (empty && q_empty))
    else $error("queues not empty after reset");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

// File: verif/tb_image_filter_3x3.sv
// ----------------------------------------------------------------------------
// tb_image_filter_3x3
// Self-checking testbench for the streaming 3x3 RGB image filter.
//
// Frames of random pixels are pushed in raster order, each followed by the
// drain ticks that flush its last pixels. Early drain ticks, surplus drain
// ticks and surplus pixels are mixed in as noise. A predictor mirrors the
// geometry, selection, kernel and clamp registers, the line buffers and the
// window. Every popped pixel is compared field by field with the oldest
// prediction. Registers are rewritten between frames, while the block is
// idle, covering every kernel, border, selection and clamp case, as well as
// tall narrow and wide short images.
// ----------------------------------------------------------------------------
`default_nettype none

class filter_scoreboard;
  localparam int LINE_LEN = 1024;

  bit [10:0] width_reg, height_reg, row_end_reg, col_end_reg;
  bit [9:0]  row_first_reg, col_first_reg;
  bit [1:0]  kind_reg;
  bit [7:0]  max_reg;
  bit [23:0] lines [2][LINE_LEN];
  bit [23:0] win [3][3];
  int unsigned in_row, in_col, out_row, out_col;
  imf_pkg::out_item_t expected_pixels[$];
  int errors;

  function new();
    width_reg = 1024; height_reg = 1024;
    row_first_reg = 0; row_end_reg = 1024;
    col_first_reg = 0; col_end_reg = 1024;
    kind_reg = imf_pkg::KIND_EDGE; max_reg = 255;
    foreach (lines[i, j]) lines[i][j] = '0;
    foreach (win[i, j]) win[i][j] = '0;
    in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    errors = 0;
  endfunction

  function void set_reg(imf_pkg::cfg_index_t idx, bit [10:0] v);
    case (idx)
      imf_pkg::CFG_IMAGE_WIDTH:   width_reg = v;
      imf_pkg::CFG_IMAGE_HEIGHT:  height_reg = v;
      imf_pkg::CFG_SEL_ROW_FIRST: row_first_reg = v[9:0];
      imf_pkg::CFG_SEL_ROW_END:   row_end_reg = v;
      imf_pkg::CFG_SEL_COL_FIRST: col_first_reg = v[9:0];
      imf_pkg::CFG_SEL_COL_END:   col_end_reg = v;
      imf_pkg::CFG_FILTER_KIND:   kind_reg = v[1:0];
      imf_pkg::CFG_MAX_VALUE:     max_reg = v[7:0];
      default: ;
    endcase
  endfunction

  function int tap(int i, int j);
    case (kind_reg)
      imf_pkg::KIND_EDGE:    return (i == 1 && j == 1) ? 8 : -1;
      imf_pkg::KIND_SHARPEN: return (i == 1 && j == 1) ? 5 : ((i == 1 || j == 1) ? -1 : 0);
      imf_pkg::KIND_BOX:     return 1;
      default:               return (i == 1 ? 2 : 1) * (j == 1 ? 2 : 1);
    endcase
  endfunction

  function bit [7:0] filtered(int k);
    int sum, d, q;
    sum = 0;
    d = (kind_reg == imf_pkg::KIND_BOX) ? 9 : (kind_reg == imf_pkg::KIND_GAUSS) ? 16 : 1;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        sum += tap(i, j) * int'(win[i][j][23 - 8 * k -: 8]);
    if (sum <= 0) return 8'd0;
    q = (2 * sum + d) / (2 * d);
    if (q > max_reg) q = max_reg;
    return q[7:0];
  endfunction

  function void note_pixel(imf_pkg::in_item_t it);
    int unsigned w, h, col;
    longint unsigned total, slot;
    bit [23:0] px;
    bit in_sel, last;
    bit [7:0] ch [3];
    imf_pkg::out_item_t exp_px;
    w = (width_reg == 0) ? 1 : (width_reg > LINE_LEN) ? LINE_LEN : width_reg;
    h = (height_reg == 0) ? 1 : height_reg;
    total = longint'(w) * h;
    slot = longint'(in_row) * w + in_col;
    px = '0;
    if (it.mode == 1'b0) begin
      if (slot < total) px = {it.in_red, it.in_green, it.in_blue};
    end else if (slot < total) begin
      return;
    end
    col = in_col % LINE_LEN;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = lines[1][col];
    win[1][2] = lines[0][col];
    win[2][2] = px;
    lines[1][col] = lines[0][col];
    lines[0][col] = px;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (slot < longint'(w) + 1) return;
    in_sel = out_row >= 1 && out_row + 1 < h && out_col >= 1 && out_col + 1 < w &&
             out_row >= row_first_reg && out_row < row_end_reg &&
             out_col >= col_first_reg && out_col < col_end_reg;
    for (int k = 0; k < 3; k++) ch[k] = in_sel ? filtered(k) : win[1][1][23 - 8 * k -: 8];
    last = (out_row >= h) || (out_row + 1 == h && out_col + 1 >= w);
    exp_px.out_red = ch[0];
    exp_px.out_green = ch[1];
    exp_px.out_blue = ch[2];
    exp_px.frame_last = last;
    expected_pixels.push_back(exp_px);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    if (last) begin
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    end
  endfunction

  function void check_pixel(imf_pkg::out_item_t got);
    imf_pkg::out_item_t exp_px;
    if (expected_pixels.size() == 0) begin
      $error("unexpected result transfer %h", got);
      errors++;
      return;
    end
    exp_px = expected_pixels.pop_front();
    if (got.out_red !== exp_px.out_red) begin
      $error("out_red expected %0d actual %0d", exp_px.out_red, got.out_red);
      errors++;
    end
    if (got.out_green !== exp_px.out_green) begin
      $error("out_green expected %0d actual %0d", exp_px.out_green, got.out_green);
      errors++;
    end
    if (got.out_blue !== exp_px.out_blue) begin
      $error("out_blue expected %0d actual %0d", exp_px.out_blue, got.out_blue);
      errors++;
    end
    if (got.frame_last !== exp_px.frame_last) begin
      $error("frame_last expected %0d actual %0d", exp_px.frame_last, got.frame_last);
      errors++;
    end
  endfunction
endclass

module tb_image_filter_3x3;
  import imf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;
  localparam int   SETTLE_CYCLES = 24;
  localparam int   CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic push = 1'b0;
  in_item_t item = '0;
  logic full, empty;
  logic pop = 1'b0;
  out_item_t result;

  filter_scoreboard sb = new();
  int cycles = 0;
  int burst_left = 0;
  int items_sent = 0;
  int pop_rate = 100;

  image_filter_3x3 dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .item(item), .full(full), .empty(empty), .pop(pop), .result(result)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_image_filter_3x3 failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_pixel(result);
    if (cycles % 80 == 0) begin
      case ($urandom_range(0, 3))
        0: pop_rate = 100;
        1: pop_rate = 70;
        2: pop_rate = 30;
        default: pop_rate = 4;
      endcase
    end
    pop <= !rst && ($urandom_range(0, 99) < pop_rate);
  end

  task automatic send_item(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_pixel(it);
    burst_left--;
    items_sent++;
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [10:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic configure(input logic [10:0] w, input logic [10:0] h,
                           input logic [10:0] rf, input logic [10:0] re,
                           input logic [10:0] cf, input logic [10:0] ce,
                           input kind_t kind, input logic [7:0] maxv);
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_SEL_ROW_FIRST, rf);
    write_reg(CFG_SEL_ROW_END, re);
    write_reg(CFG_SEL_COL_FIRST, cf);
    write_reg(CFG_SEL_COL_END, ce);
    write_reg(CFG_FILTER_KIND, 11'(kind));
    write_reg(CFG_MAX_VALUE, 11'(maxv));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic in_item_t rand_pixel();
    in_item_t it;
    it.mode = MODE_PIXEL;
    it.in_red = rand_chan();
    it.in_green = rand_chan();
    it.in_blue = rand_chan();
    return it;
  endfunction

  task automatic run_frame(input int w, input int h, input int noise);
    in_item_t it;
    for (int i = 0; i < w * h; i++) begin
      if (noise > 0 && $urandom_range(0, 99) < noise) begin
        it = rand_pixel();
        it.mode = MODE_DRAIN;
        send_item(it);
      end
      send_item(rand_pixel());
    end
    for (int i = 0; i < w + 1 + (noise > 0 ? $urandom_range(0, 2) : 0); i++) begin
      it = rand_pixel();
      if (noise == 0 || $urandom_range(0, 4) != 0) it.mode = MODE_DRAIN;
      send_item(it);
    end
  endtask

  function automatic logic [10:0] rand_bound(input int lim);
    case ($urandom_range(0, 5))
      0: return 11'($urandom_range(0, 2047));
      1: return 11'(0);
      2: return 11'(1024);
      default: return 11'($urandom_range(0, lim));
    endcase
  endfunction

  initial begin
    in_item_t it;
    int w, h, phase;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: 3x3 frame of extremes with early and surplus drain ticks
    configure(11'd3, 11'd3, 11'd0, 11'd1024, 11'd0, 11'd1024, KIND_EDGE, 8'd255);
    for (int i = 0; i < 9; i++) begin
      it.mode = MODE_PIXEL;
      it.in_red = (i % 2) ? 8'd255 : 8'd0;
      it.in_green = (i == 4) ? 8'd255 : 8'd0;
      it.in_blue = (i == 4) ? 8'd0 : 8'd255;
      if (i == 5) begin
        it.mode = MODE_DRAIN;
        send_item(it);
        it.mode = MODE_PIXEL;
      end
      send_item(it);
    end
    it = '0;
    it.mode = MODE_DRAIN;
    for (int i = 0; i < 3; i++) send_item(it);
    send_item(rand_pixel());
    send_item(it);

    // zero width and height become a single pixel
    configure(11'd0, 11'd0, 11'd0, 11'd1024, 11'd0, 11'd1024, KIND_SHARPEN, 8'd255);
    run_frame(1, 1, 0);
    // max value zero, reversed selection afterwards
    configure(11'd3, 11'd3, 11'd0, 11'd1024, 11'd0, 11'd1024, KIND_GAUSS, 8'd0);
    run_frame(3, 3, 0);
    configure(11'd4, 11'd3, 11'd2, 11'd1, 11'd0, 11'd1024, KIND_BOX, 8'd1);
    run_frame(4, 3, 0);

    phase = 0;
    while (items_sent < 280) begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      configure(11'(w), 11'(h), rand_bound(h), rand_bound(h + 1), rand_bound(w),
                rand_bound(w + 1), kind_t'(phase % 4),
                ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255)) : 8'd255);
      run_frame(w, h, 6);
      phase++;
    end

    // tall narrow and wide short images
    configure(11'd1, 11'd24, 11'd0, 11'd2047, 11'd0, 11'd2047, KIND_GAUSS, 8'd128);
    run_frame(1, 24, 0);
    configure(11'd24, 11'd2, 11'd0, 11'd1024, 11'd1, 11'd23, KIND_EDGE, 8'd200);
    run_frame(24, 2, 0);

    wait_idle();
    if (sb.errors == 0) begin
      $display("tb_image_filter_3x3 passed");
    end else begin
      $display("tb_image_filter_3x3 failed");
    end
    $finish;
  end
endmodule

`default_nettype wire

// File: sim.f
hdl/imf_pkg.sv
hdl/imf_ram.sv
hdl/imf_fifo.sv
hdl/imf_front.sv
hdl/imf_back.sv
hdl/image_filter_3x3.sv
verif/tb_image_filter_3x3.sv
